>>> design/fractional_clock_divider_search_assert.svh
// Assertion macros for the fractional clock divider search block.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef FRACTIONAL_CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define FRACTIONAL_CLOCK_DIVIDER_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FCDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcds: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FCDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcds: next-cycle check failed");

`else

`define FCDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCDS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/fcds_pkg.sv
// Package for the fractional clock divider search: widths, constants,
// sequencer states and the divider request/response structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcds_pkg;

	localparam int RATE_W   = 20;
	localparam int WWIDTH_W = 6;
	localparam int CLK_W    = 32;
	localparam int BITS_W   = 28;
	localparam int FRAC_W   = 16;
	localparam int DIVD_W   = BITS_W + FRAC_W;
	localparam int CNT_W    = $clog2(DIVD_W + 1);
	localparam int N_W      = 7;
	localparam int Y_W      = 8;
	localparam int X_W      = 8;
	localparam int YN_W     = N_W + Y_W;

	localparam int MAX_N = 64;
	localparam int MAX_Y = 255;

	localparam logic [CLK_W-1:0]  PCLK_RESET = 32'd96000000;
	localparam logic [FRAC_W-1:0] FRAC_HALF  = 16'h8000;
	localparam logic [FRAC_W:0]   FRAC_ONE   = 17'h10000;
	localparam logic [FRAC_W-1:0] ERR_INIT   = 16'hFFFF;
	localparam logic [X_W-1:0]    X_MAX      = 8'hFF;
	localparam logic [X_W-1:0]    X_MIN      = 8'h01;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_NO_N = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATIO,
		ST_NSEARCH,
		ST_YSEARCH,
		ST_YN,
		ST_XPROD,
		ST_XDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [CLK_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> design/fractional_clock_divider_search.sv
// Top level of the fractional clock divider search: sequencer, N and y
// search datapath, config register. Depends on fcds_pkg, fcds_div and the assert header.
//
//   channel   ports                                           direction
//   request   start, sample_rate, word_width / busy           in / out
//   result    done, x_divider, y_divider, n_divider, status   out
//   config    cfg_valid, peripheral_clock_hz / cfg_ready      in / out
//
// The done strobe follows the accepting edge; busy drops in the cycle after done. Each
// 44-step pass of the shared serial divider yields the ratio or x; the N search tries N
// from 64 down to 1, the y search y from 255 down to 1, and ST_YN then ST_XPROD form y*N.
// A zero clock strobes done in the cycle after the accept, a ratio of one or more after
// the first pass. Reset returns the sequencer to idle and the clock register to 96 MHz.
// Results are shown for one cycle and the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none
`include "fractional_clock_divider_search_assert.svh"

module fractional_clock_divider_search (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [fcds_pkg::RATE_W-1:0]     sample_rate,
	input  wire logic [fcds_pkg::WWIDTH_W-1:0]   word_width,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fcds_pkg::CLK_W-1:0]      peripheral_clock_hz,
	output logic                                 done,
	output logic [fcds_pkg::X_W-1:0]             x_divider,
	output logic [fcds_pkg::Y_W-1:0]             y_divider,
	output logic [fcds_pkg::N_W-1:0]             n_divider,
	output logic                                 status
);

	fcds_pkg::state_t state_q, state_d;

	logic [fcds_pkg::CLK_W-1:0]    pclk_q;
	logic [fcds_pkg::BITS_W-1:0]   bits_q;
	logic [fcds_pkg::FRAC_W-1:0]   ratio_q;
	logic [fcds_pkg::N_W-1:0]      n_q;
	logic [fcds_pkg::FRAC_W-1:0]   r_q;
	logic [fcds_pkg::Y_W-1:0]      y_q;
	logic [fcds_pkg::Y_W-1:0]      best_y_q;
	logic [fcds_pkg::FRAC_W-1:0]   best_err_q;
	logic [fcds_pkg::YN_W-1:0]     yn_q;
	logic [fcds_pkg::X_W-1:0]      x_q;
	logic [fcds_pkg::Y_W-1:0]      yo_q;
	logic [fcds_pkg::N_W-1:0]      no_q;
	logic                          st_q;

	logic                                        accept;
	logic [fcds_pkg::BITS_W-3:0]                 rw;
	logic [fcds_pkg::BITS_W-1:0]                 bits_d;
	logic [fcds_pkg::FRAC_W+fcds_pkg::N_W-1:0]   n_prod;
	logic                                        n_fit;
	logic [fcds_pkg::FRAC_W+fcds_pkg::Y_W-1:0]   y_prod;
	logic [fcds_pkg::FRAC_W-1:0]                 frac;
	logic [fcds_pkg::FRAC_W-1:0]                 err;
	logic                                        err_better;
	logic                                        y_stop;
	logic                                        ratio_big;
	logic [fcds_pkg::X_W-1:0]                    x_clamp;
	fcds_pkg::div_req_t                          div_req;
	fcds_pkg::div_rsp_t                          div_rsp;
	logic                                        err_done;
	logic                                        ok_done;
	logic                                        fields_zero;
	logic                                        fields_ok;

	fcds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != fcds_pkg::ST_IDLE);
	assign done      = (state_q == fcds_pkg::ST_DONE);
	assign cfg_ready = 1'b1;

	assign x_divider = x_q;
	assign y_divider = yo_q;
	assign n_divider = no_q;
	assign status    = st_q;

	always_comb begin
		rw     = (fcds_pkg::BITS_W-2)'(sample_rate) * (fcds_pkg::BITS_W-2)'(word_width);
		bits_d = {rw, 2'b00};

		n_prod = (fcds_pkg::FRAC_W+fcds_pkg::N_W)'(ratio_q)
			* (fcds_pkg::FRAC_W+fcds_pkg::N_W)'(n_q);
		n_fit  = (n_prod[fcds_pkg::FRAC_W+fcds_pkg::N_W-1:fcds_pkg::FRAC_W] == '0);

		// Rounding error is the distance of y*R to the nearest whole number.
		y_prod = (fcds_pkg::FRAC_W+fcds_pkg::Y_W)'(r_q)
			* (fcds_pkg::FRAC_W+fcds_pkg::Y_W)'(y_q);
		frac   = y_prod[fcds_pkg::FRAC_W-1:0];
		if (frac > fcds_pkg::FRAC_HALF) begin
			err = fcds_pkg::FRAC_W'(fcds_pkg::FRAC_ONE - {1'b0, frac});
		end else begin
			err = frac;
		end
		err_better = (err < best_err_q);
		y_stop     = (err == '0) || (y_q == fcds_pkg::Y_W'(1));

		ratio_big = (div_rsp.quotient[fcds_pkg::DIVD_W-1:fcds_pkg::FRAC_W] != '0);

		priority if (div_rsp.quotient[fcds_pkg::DIVD_W-1:fcds_pkg::X_W] != '0) begin
			x_clamp = fcds_pkg::X_MAX;
		end else if (div_rsp.quotient[fcds_pkg::X_W-1:0] == '0) begin
			x_clamp = fcds_pkg::X_MIN;
		end else begin
			x_clamp = div_rsp.quotient[fcds_pkg::X_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcds_pkg::ST_IDLE;
			pclk_q  <= fcds_pkg::PCLK_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				pclk_q <= peripheral_clock_hz;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = {bits_d, fcds_pkg::FRAC_W'(0)};
		div_req.divisor  = pclk_q;
		unique case (state_q)
			fcds_pkg::ST_IDLE: begin
				if (accept) begin
					if (pclk_q == '0) begin
						state_d = fcds_pkg::ST_DONE;
					end else begin
						div_req.start = 1'b1;
						state_d       = fcds_pkg::ST_RATIO;
					end
				end
			end
			fcds_pkg::ST_RATIO: begin
				if (div_rsp.done) begin
					state_d = ratio_big ? fcds_pkg::ST_DONE : fcds_pkg::ST_NSEARCH;
				end
			end
			fcds_pkg::ST_NSEARCH: begin
				if (n_fit) begin
					state_d = fcds_pkg::ST_YSEARCH;
				end else if (n_q == fcds_pkg::N_W'(1)) begin
					state_d = fcds_pkg::ST_DONE;
				end
			end
			fcds_pkg::ST_YSEARCH: begin
				if (y_stop) begin
					state_d = fcds_pkg::ST_YN;
				end
			end
			fcds_pkg::ST_YN: begin
				state_d = fcds_pkg::ST_XPROD;
			end
			fcds_pkg::ST_XPROD: begin
				div_req.start    = 1'b1;
				div_req.dividend = fcds_pkg::DIVD_W'(
					(fcds_pkg::DIVD_W)'(yn_q) * (fcds_pkg::DIVD_W)'(bits_q));
				state_d          = fcds_pkg::ST_XDIV;
			end
			fcds_pkg::ST_XDIV: begin
				if (div_rsp.done) begin
					state_d = fcds_pkg::ST_DONE;
				end
			end
			fcds_pkg::ST_DONE: begin
				state_d = fcds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fcds_pkg::ST_IDLE: begin
				if (accept) begin
					bits_q <= bits_d;
					if (pclk_q == '0) begin
						x_q  <= '0;
						yo_q <= '0;
						no_q <= '0;
						st_q <= fcds_pkg::STATUS_NO_N;
					end
				end
			end
			fcds_pkg::ST_RATIO: begin
				if (div_rsp.done) begin
					ratio_q <= div_rsp.quotient[fcds_pkg::FRAC_W-1:0];
					n_q     <= fcds_pkg::N_W'(fcds_pkg::MAX_N);
					if (ratio_big) begin
						x_q  <= '0;
						yo_q <= '0;
						no_q <= '0;
						st_q <= fcds_pkg::STATUS_NO_N;
					end
				end
			end
			fcds_pkg::ST_NSEARCH: begin
				if (n_fit) begin
					r_q        <= n_prod[fcds_pkg::FRAC_W-1:0];
					y_q        <= fcds_pkg::Y_W'(fcds_pkg::MAX_Y);
					best_y_q   <= '0;
					best_err_q <= fcds_pkg::ERR_INIT;
				end else begin
					n_q <= n_q - 1'b1;
					if (n_q == fcds_pkg::N_W'(1)) begin
						x_q  <= '0;
						yo_q <= '0;
						no_q <= '0;
						st_q <= fcds_pkg::STATUS_NO_N;
					end
				end
			end
			fcds_pkg::ST_YSEARCH: begin
				// Strictly smaller error wins, so ties keep the larger y.
				if (err_better) begin
					best_y_q   <= y_q;
					best_err_q <= err;
				end
				y_q <= y_q - 1'b1;
			end
			fcds_pkg::ST_YN: begin
				yn_q <= fcds_pkg::YN_W'(best_y_q) * fcds_pkg::YN_W'(n_q);
			end
			fcds_pkg::ST_XPROD: begin
				yn_q <= yn_q;
			end
			fcds_pkg::ST_XDIV: begin
				if (div_rsp.done) begin
					x_q  <= x_clamp;
					yo_q <= best_y_q;
					no_q <= n_q;
					st_q <= fcds_pkg::STATUS_OK;
				end
			end
			fcds_pkg::ST_DONE: begin
				bits_q <= bits_q;
			end
		endcase
	end

	assign err_done    = done && (status == fcds_pkg::STATUS_NO_N);
	assign ok_done     = done && (status == fcds_pkg::STATUS_OK);
	assign fields_zero = (x_divider == '0) && (y_divider == '0) && (n_divider == '0);
	assign fields_ok   = (x_divider != '0) && (y_divider != '0) && (n_divider != '0)
		&& (n_divider <= fcds_pkg::N_W'(fcds_pkg::MAX_N));

	`FCDS_ASSERT_IMP(a_error_fields_zero, clk, arst_n, err_done, fields_zero)
	`FCDS_ASSERT_IMP(a_ok_fields_range, clk, arst_n, ok_done, fields_ok)
	`FCDS_ASSERT_NXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy)
	`FCDS_ASSERT_NXT(a_done_single_cycle, clk, arst_n, done, !done && !busy)

endmodule

`default_nettype wire

>>> design/fcds_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the
// ratio and x computations. Depends on fcds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcds_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fcds_pkg::div_req_t req,
	output fcds_pkg::div_rsp_t     rsp
);

	logic [fcds_pkg::CLK_W-1:0]  rem_q;
	logic [fcds_pkg::DIVD_W-1:0] quo_q;
	logic [fcds_pkg::CLK_W-1:0]  divisor_q;
	logic [fcds_pkg::CNT_W-1:0]  cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [fcds_pkg::CLK_W:0]    trial;
	logic [fcds_pkg::CLK_W:0]    diff;
	logic                        qbit;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[fcds_pkg::DIVD_W-1]};
		diff  = trial - {1'b0, divisor_q};
		qbit  = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= fcds_pkg::CNT_W'(fcds_pkg::DIVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == fcds_pkg::CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= qbit ? diff[fcds_pkg::CLK_W-1:0] : trial[fcds_pkg::CLK_W-1:0];
			quo_q <= {quo_q[fcds_pkg::DIVD_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire
